FILE: rtl/core/wavp_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM parser package
// Item types, result kinds and error codes shared by the parser files.
// ----------------------------------------------------------------------------
package wavp_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [3:0] ERR_NO_RIFF   = 4'd0;
  localparam logic [3:0] ERR_NO_WAVE   = 4'd1;
  localparam logic [3:0] ERR_FMT_SMALL = 4'd2;
  localparam logic [3:0] ERR_NO_FMT    = 4'd3;
  localparam logic [3:0] ERR_NO_DATA   = 4'd4;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
  localparam logic [3:0] ERR_NOT_MONO  = 4'd6;
  localparam logic [3:0] ERR_NOT_16BIT = 4'd7;
  localparam logic [3:0] ERR_ODD_DATA  = 4'd8;
  localparam logic [3:0] ERR_EARLY_END = 4'd9;

  // Four-character tags as they read when assembled low byte first.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
  localparam logic [15:0] FMT_PCM       = 16'd1;
  localparam logic [15:0] FMT_MONO      = 16'd1;
  localparam logic [15:0] FMT_BITS_16   = 16'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    logic [3:0]         error_code;
    logic               last;
  } out_item_t;

endpackage

FILE: rtl/core/wavp_if.sv
// ----------------------------------------------------------------------------
// WAV PCM parser channels
// Byte input channel and result output channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface wavp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface wavp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [31:0]        sample_rate;
  logic [3:0]         error_code;
  logic               last;

  modport source (output valid, output kind, output sample, output sample_rate,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input sample, input sample_rate,
                  input error_code, input last, output ready);
endinterface

FILE: rtl/core/wav_pcm16_mono_stream_parser_core.sv
// ----------------------------------------------------------------------------
// WAV PCM16 mono stream parser
// Walks a RIFF/WAVE byte stream and emits 16-bit mono PCM samples.
// ----------------------------------------------------------------------------
// One byte is taken per request, and a new byte can be taken in every clock
// cycle. A byte passes through an input register, one step of the header walk
// and a result register, from which its result is offered. The result register
// decouples the two channels: input stalls only when a result is waiting and
// the consumer holds ready low. At most one result comes out per byte; a sample
// needs two bytes. After the result marked last every further byte is accepted
// and dropped until reset.
module wav_pcm16_mono_stream_parser_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wavp_byte_if.sink            byte_i,
  wavp_result_if.source        result_o
);

  logic                in_vld_q, in_vld_d;
  wavp_pkg::in_item_t  in_item_q;
  logic                out_vld_q, out_vld_d;
  wavp_pkg::out_item_t out_item_q;

  logic                advance;
  logic                step;
  logic                res_valid;
  wavp_pkg::out_item_t res;

  // The walk step may run whenever the result register is free or emptying.
  assign advance      = !out_vld_q || result_o.ready;
  assign step         = in_vld_q && advance;
  assign byte_i.ready = !in_vld_q || advance;

  assign in_vld_d  = byte_i.ready ? byte_i.valid : in_vld_q;
  assign out_vld_d = advance ? (step && res_valid) : out_vld_q;

  wavp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_item_q.data_byte   <= byte_i.data_byte;
      in_item_q.end_of_file <= byte_i.end_of_file;
    end
    if (step && res_valid) begin
      out_item_q <= res;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.kind        = out_item_q.kind;
  assign result_o.sample      = out_item_q.sample;
  assign result_o.sample_rate = out_item_q.sample_rate;
  assign result_o.error_code  = out_item_q.error_code;
  assign result_o.last        = out_item_q.last;

endmodule

FILE: rtl/core/wavp_parse.sv
// ----------------------------------------------------------------------------
// WAV PCM parser state walk
// Holds the header walk state and turns one byte per step into at most one
// result: sample, header accepted, error or data finished.
// ----------------------------------------------------------------------------
module wavp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  wavp_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output wavp_pkg::out_item_t res_o
);

  localparam logic [3:0] PH_RIFF_ID    = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE_ID    = 4'd2;
  localparam logic [3:0] PH_CHUNK_ID   = 4'd3;
  localparam logic [3:0] PH_CHUNK_SIZE = 4'd4;
  localparam logic [3:0] PH_FMT_TAG    = 4'd5;
  localparam logic [3:0] PH_FMT_CH     = 4'd6;
  localparam logic [3:0] PH_FMT_RATE   = 4'd7;
  localparam logic [3:0] PH_FMT_BRATE  = 4'd8;
  localparam logic [3:0] PH_FMT_ALIGN  = 4'd9;
  localparam logic [3:0] PH_FMT_BITS   = 4'd10;
  localparam logic [3:0] PH_SKIP       = 4'd11;
  localparam logic [3:0] PH_PAD        = 4'd12;
  localparam logic [3:0] PH_DATA       = 4'd13;
  localparam logic [3:0] PH_EMPTY      = 4'd14;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [23:0] field_q, field_d;
  logic        is_fmt_q, is_fmt_d;
  logic        is_data_q, is_data_d;
  logic [31:0] skip_q, skip_d;
  logic        pad_q, pad_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        pcm_q, pcm_d;
  logic        mono_q, mono_d;
  logic        bits16_q, bits16_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] data_rem_q, data_rem_d;
  logic [7:0]  low_q, low_d;
  logic        finished_q, finished_d;

  logic [7:0]  b;
  logic [31:0] word_v;
  logic [15:0] half_v;
  logic        done4, done2;
  logic [3:0]  after_chunk;

  assign b      = item_i.data_byte;
  assign word_v = {b, field_q};
  assign half_v = {b, field_q[7:0]};
  assign done4  = (cnt_q == 2'd3);
  assign done2  = (cnt_q == 2'd1);

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    field_d    = field_q;
    is_fmt_d   = is_fmt_q;
    is_data_d  = is_data_q;
    skip_d     = skip_q;
    pad_d      = pad_q;
    fmt_seen_d = fmt_seen_q;
    pcm_d      = pcm_q;
    mono_d     = mono_q;
    bits16_d   = bits16_q;
    rate_d     = rate_q;
    data_rem_d = data_rem_q;
    low_d      = low_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    after_chunk = pad_q ? PH_PAD : PH_CHUNK_ID;

    if (step_i && !finished_q) begin
      if (phase_q == PH_EMPTY) begin
        res_valid_o = 1'b1;
        res_o.kind  = wavp_pkg::KIND_DONE;
        res_o.last  = 1'b1;
      end else if (item_i.end_of_file) begin
        res_valid_o = 1'b1;
        res_o.kind  = wavp_pkg::KIND_ERROR;
        res_o.last  = 1'b1;
        if (phase_q == PH_CHUNK_ID || phase_q == PH_SKIP || phase_q == PH_PAD) begin
          res_o.error_code = fmt_seen_q ? wavp_pkg::ERR_NO_DATA : wavp_pkg::ERR_NO_FMT;
        end else begin
          res_o.error_code = wavp_pkg::ERR_EARLY_END;
        end
      end else begin
        // Byte gathering for fixed fields: the final byte completes the value
        // combinationally, earlier bytes land in the field register.
        if (phase_q != PH_SKIP && phase_q != PH_PAD && phase_q != PH_DATA) begin
          cnt_d = cnt_q + 2'd1;
          case (cnt_q)
            2'd0:    field_d[7:0]   = b;
            2'd1:    field_d[15:8]  = b;
            2'd2:    field_d[23:16] = b;
            default: field_d        = field_q;
          endcase
        end

        case (phase_q)
          PH_RIFF_ID: begin
            if (done4) begin
              cnt_d = 2'd0;
              if (word_v != wavp_pkg::TAG_RIFF) begin
                res_valid_o      = 1'b1;
                res_o.kind       = wavp_pkg::KIND_ERROR;
                res_o.error_code = wavp_pkg::ERR_NO_RIFF;
                res_o.last       = 1'b1;
              end else begin
                phase_d = PH_RIFF_SIZE;
              end
            end
          end
          PH_RIFF_SIZE: begin
            if (done4) begin
              cnt_d   = 2'd0;
              phase_d = PH_WAVE_ID;
            end
          end
          PH_WAVE_ID: begin
            if (done4) begin
              cnt_d = 2'd0;
              if (word_v != wavp_pkg::TAG_WAVE) begin
                res_valid_o      = 1'b1;
                res_o.kind       = wavp_pkg::KIND_ERROR;
                res_o.error_code = wavp_pkg::ERR_NO_WAVE;
                res_o.last       = 1'b1;
              end else begin
                phase_d = PH_CHUNK_ID;
              end
            end
          end
          PH_CHUNK_ID: begin
            if (done4) begin
              cnt_d     = 2'd0;
              is_fmt_d  = (word_v == wavp_pkg::TAG_FMT);
              is_data_d = (word_v == wavp_pkg::TAG_DATA);
              phase_d   = PH_CHUNK_SIZE;
            end
          end
          PH_CHUNK_SIZE: begin
            if (done4) begin
              cnt_d = 2'd0;
              pad_d = word_v[0];
              if (is_fmt_q) begin
                if (word_v < wavp_pkg::FMT_MIN_LEN) begin
                  res_valid_o      = 1'b1;
                  res_o.kind       = wavp_pkg::KIND_ERROR;
                  res_o.error_code = wavp_pkg::ERR_FMT_SMALL;
                  res_o.last       = 1'b1;
                end else begin
                  skip_d  = word_v - wavp_pkg::FMT_MIN_LEN;
                  phase_d = PH_FMT_TAG;
                end
              end else if (is_data_q) begin
                res_valid_o = 1'b1;
                res_o.kind  = wavp_pkg::KIND_ERROR;
                res_o.last  = 1'b1;
                if (!fmt_seen_q) begin
                  res_o.error_code = wavp_pkg::ERR_NO_FMT;
                end else if (!pcm_q) begin
                  res_o.error_code = wavp_pkg::ERR_NOT_PCM;
                end else if (!mono_q) begin
                  res_o.error_code = wavp_pkg::ERR_NOT_MONO;
                end else if (!bits16_q) begin
                  res_o.error_code = wavp_pkg::ERR_NOT_16BIT;
                end else if (word_v[0]) begin
                  res_o.error_code = wavp_pkg::ERR_ODD_DATA;
                end else begin
                  res_o.kind        = wavp_pkg::KIND_HEADER;
                  res_o.sample_rate = rate_q;
                  res_o.last        = 1'b0;
                  data_rem_d        = word_v;
                  phase_d           = (word_v != 32'd0) ? PH_DATA : PH_EMPTY;
                end
              end else begin
                // An unknown chunk is skipped, with a pad byte after an odd length; a zero
                // length goes straight on to the next chunk tag.
                skip_d  = word_v;
                phase_d = (word_v != 32'd0) ? PH_SKIP
                                            : (word_v[0] ? PH_PAD : PH_CHUNK_ID);
              end
            end
          end
          PH_FMT_TAG: begin
            if (done2) begin
              cnt_d   = 2'd0;
              pcm_d   = (half_v == wavp_pkg::FMT_PCM);
              phase_d = PH_FMT_CH;
            end
          end
          PH_FMT_CH: begin
            if (done2) begin
              cnt_d   = 2'd0;
              mono_d  = (half_v == wavp_pkg::FMT_MONO);
              phase_d = PH_FMT_RATE;
            end
          end
          PH_FMT_RATE: begin
            if (done4) begin
              cnt_d   = 2'd0;
              rate_d  = word_v;
              phase_d = PH_FMT_BRATE;
            end
          end
          PH_FMT_BRATE: begin
            if (done4) begin
              cnt_d   = 2'd0;
              phase_d = PH_FMT_ALIGN;
            end
          end
          PH_FMT_ALIGN: begin
            if (done2) begin
              cnt_d   = 2'd0;
              phase_d = PH_FMT_BITS;
            end
          end
          PH_FMT_BITS: begin
            if (done2) begin
              cnt_d      = 2'd0;
              bits16_d   = (half_v == wavp_pkg::FMT_BITS_16);
              fmt_seen_d = 1'b1;
              phase_d    = (skip_q != 32'd0) ? PH_SKIP : after_chunk;
            end
          end
          PH_SKIP: begin
            if (skip_q != 32'd0) begin
              skip_d = skip_q - 32'd1;
            end
            if (skip_q <= 32'd1) begin
              phase_d = after_chunk;
            end
          end
          PH_PAD: begin
            pad_d   = 1'b0;
            phase_d = PH_CHUNK_ID;
          end
          PH_DATA: begin
            if (cnt_q == 2'd0) begin
              low_d = b;
              cnt_d = 2'd1;
            end else begin
              cnt_d        = 2'd0;
              data_rem_d   = (data_rem_q >= 32'd2) ? data_rem_q - 32'd2 : 32'd0;
              res_valid_o  = 1'b1;
              res_o.kind   = wavp_pkg::KIND_SAMPLE;
              res_o.sample = $signed({b, low_q});
              res_o.last   = (data_rem_q <= 32'd2);
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  assign finished_d = finished_q | (res_valid_o & res_o.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF_ID;
      cnt_q      <= 2'd0;
      field_q    <= '0;
      is_fmt_q   <= 1'b0;
      is_data_q  <= 1'b0;
      skip_q     <= '0;
      pad_q      <= 1'b0;
      fmt_seen_q <= 1'b0;
      pcm_q      <= 1'b0;
      mono_q     <= 1'b0;
      bits16_q   <= 1'b0;
      rate_q     <= '0;
      data_rem_q <= '0;
      low_q      <= '0;
      finished_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      field_q    <= field_d;
      is_fmt_q   <= is_fmt_d;
      is_data_q  <= is_data_d;
      skip_q     <= skip_d;
      pad_q      <= pad_d;
      fmt_seen_q <= fmt_seen_d;
      pcm_q      <= pcm_d;
      mono_q     <= mono_d;
      bits16_q   <= bits16_d;
      rate_q     <= rate_d;
      data_rem_q <= data_rem_d;
      low_q      <= low_d;
      finished_q <= finished_d;
    end
  end

endmodule

FILE: rtl/core/wavp_checker.sv
// ----------------------------------------------------------------------------
// WAV PCM parser port checker
// Watches the parser's ports for handshake and result rules over time.
// ----------------------------------------------------------------------------
module wavp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         kind_i,
  input logic signed [15:0] sample_i,
  input logic [31:0]        sample_rate_i,
  input logic [3:0]         error_code_i,
  input logic               last_i
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(sample_i)
      && $stable(sample_rate_i) && $stable(error_code_i) && $stable(last_i))
    else $error("result changed while stalled");

  // Input is never held off while the result side is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no result pending");

  // Once the final result is taken nothing follows it, whatever arrives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_i |=> !out_valid_i)
    else $error("result after the final one");

  // Errors and the data-finished result always end the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == wavp_pkg::KIND_ERROR || kind_i == wavp_pkg::KIND_DONE)
      |-> last_i && sample_i == 16'sd0 && sample_rate_i == 32'd0)
    else $error("terminal result malformed");

  // A header result, checked while input is valid, is never last and carries no sample or error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == wavp_pkg::KIND_HEADER && in_valid_i
      |-> !last_i && sample_i == 16'sd0 && error_code_i == 4'd0)
    else $error("header result malformed");

endmodule

bind wav_pcm16_mono_stream_parser_core wavp_checker u_wavp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .kind_i        (result_o.kind),
  .sample_i      (result_o.sample),
  .sample_rate_i (result_o.sample_rate),
  .error_code_i  (result_o.error_code),
  .last_i        (result_o.last)
);
